// ===== rtl/wpm_pkg.sv =====
// Package for the wildcard pattern matcher.
// Shared constants, opcodes and the cell control struct; no dependencies.
`default_nettype none

package wpm_pkg;

   localparam int PATTERN_MAX_DEF = 64;
   localparam int CHAR_W          = 8;
   localparam int POS_W           = 32;
   localparam int OP_W            = 2;

   localparam logic [CHAR_W-1:0] WILDCARD_RESET = 8'd63;

   typedef enum logic [OP_W-1:0] {
      OP_PATTERN = 2'd0,
      OP_TEXT    = 2'd1,
      OP_CLEAR   = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   // per-cycle control broadcast to every cell
   typedef struct packed {
      logic shift_r;   // pattern append: reversed pattern moves one cell up
      logic copy_a;    // aligned pattern reloads from reversed pattern
      logic shift_a;   // alignment pass: aligned pattern moves one cell down
      logic shift_t;   // text transfer: window moves one cell up
   } ctl_type;

endpackage

`default_nettype wire

// ===== rtl/wpm_cell.sv =====
// One cell of the matcher chain: a reversed pattern byte, an aligned pattern byte
// and a text window byte, with its compare. Depends on wpm_pkg.
`default_nettype none

module wpm_cell
   import wpm_pkg::*;
(
   input  wire logic              clock,
   input  wire ctl_type           ctl,
   input  wire logic [CHAR_W-1:0] wild,
   input  wire logic [CHAR_W-1:0] r_prev,
   input  wire logic [CHAR_W-1:0] t_prev,
   input  wire logic [CHAR_W-1:0] a_next,
   output logic      [CHAR_W-1:0] r_out,
   output logic      [CHAR_W-1:0] t_out,
   output logic      [CHAR_W-1:0] a_out,
   output logic                   hit
);

   logic [CHAR_W-1:0] r_ff, r_in;
   logic [CHAR_W-1:0] t_ff;
   logic [CHAR_W-1:0] a_ff, a_in;

   always_comb begin
      r_in = ctl.shift_r ? r_prev : r_ff;
      priority if (ctl.copy_a) begin
         a_in = r_in;
      end else if (ctl.shift_a) begin
         a_in = a_next;
      end else begin
         a_in = a_ff;
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      a_ff <= a_in;
      if (ctl.shift_t) begin
         t_ff <= t_prev;
      end
   end

   assign r_out = r_ff;
   assign t_out = t_ff;
   assign a_out = a_ff;
   assign hit   = (a_ff == wild) || (a_ff == t_ff);

endmodule

`default_nettype wire

// ===== rtl/wildcard_pattern_matcher.sv =====
// A text byte waits in pend_ff; its result is registered in rsp_valid_ff.
// Throughput: one item per cycle unless rsp_ready stalls or alignment runs.
// After a wildcard write req_ready is low while the aligned pattern
// shifts down past its trailing wildcards.
// Reset (synchronous, active high): pattern and text empty, wildcard '?' (63).
// Depends on wpm_pkg and wpm_cell.
`default_nettype none

module wildcard_pattern_matcher
   import wpm_pkg::*;
#(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF
)(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [OP_W-1:0]   req_opcode,
   input  wire logic [CHAR_W-1:0] req_char_byte,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic      [POS_W-1:0]  rsp_match_start,
   input  wire logic              csr_wr_en,
   input  wire logic [CHAR_W-1:0] csr_wr_data
);

   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int OFF_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);

   logic [CHAR_W-1:0] wild_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  fill_ff;
   logic [OFF_W-1:0]  last_ff;
   logic              fixed_ff;
   logic              align_ff;
   logic              pend_ff;
   logic [POS_W-1:0]  pos_ff;
   logic              rsp_valid_ff;
   logic [POS_W-1:0]  rsp_start_ff;

   logic [CHAR_W-1:0] r_w [PATTERN_MAX];
   logic [CHAR_W-1:0] t_w [PATTERN_MAX];
   logic [CHAR_W-1:0] a_w [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] hit_w;
   logic [PATTERN_MAX-1:0] cmp_en;

   ctl_type    ctl;
   opcode_type op;
   logic       req_fire, op_pat, pat_fixed, op_text, op_clear;
   logic       out_busy, advance, all_hit, match, align_step, a0_wild;

   assign op       = opcode_type'(req_opcode);
   assign out_busy = rsp_valid_ff && !rsp_ready;
   assign advance  = pend_ff && !out_busy;
   assign req_ready = !align_ff && !(pend_ff && out_busy);
   assign req_fire  = req_valid && req_ready;

   assign op_pat    = req_fire && (op == OP_PATTERN) && (len_ff < LEN_MAX);
   assign pat_fixed = op_pat && (req_char_byte != wild_ff);
   assign op_text   = req_fire && (op == OP_TEXT);
   assign op_clear  = req_fire && (op == OP_CLEAR);

   assign a0_wild    = (a_w[0] == wild_ff);
   assign align_step = align_ff && fixed_ff && a0_wild && (last_ff != '0);

   always_comb begin
      ctl.shift_r = op_pat;
      ctl.copy_a  = pat_fixed || csr_wr_en;
      ctl.shift_a = align_step;
      ctl.shift_t = op_text;
   end

   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      logic [CHAR_W-1:0] r_prev, t_prev, a_next;
      if (j == 0) begin : g_first
         assign r_prev = req_char_byte;
         assign t_prev = req_char_byte;
      end else begin : g_mid
         assign r_prev = r_w[j-1];
         assign t_prev = t_w[j-1];
      end
      if (j == PATTERN_MAX - 1) begin : g_last
         assign a_next = '0;
      end else begin : g_inner
         assign a_next = a_w[j+1];
      end
      // cell j is compared only while it lies within the aligned pattern
      assign cmp_en[j] = (OFF_W'(j) <= last_ff);

      wpm_cell u_cell (
         .clock  (clock),
         .ctl    (ctl),
         .wild   (wild_ff),
         .r_prev (r_prev),
         .t_prev (t_prev),
         .a_next (a_next),
         .r_out  (r_w[j]),
         .t_out  (t_w[j]),
         .a_out  (a_w[j]),
         .hit    (hit_w[j])
      );
   end

   assign all_hit = &(hit_w | ~cmp_en);
   assign match   = !fixed_ff || (all_hit && (fill_ff > LEN_W'(last_ff)));

   always_ff @(posedge clock) begin
      if (reset) begin
         wild_ff      <= WILDCARD_RESET;
         len_ff       <= '0;
         fill_ff      <= '0;
         last_ff      <= '0;
         fixed_ff     <= 1'b0;
         align_ff     <= 1'b0;
         pend_ff      <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // pattern bookkeeping and alignment
         priority if (csr_wr_en) begin
            wild_ff  <= csr_wr_data;
            align_ff <= 1'b1;
            fixed_ff <= (len_ff != '0);
            last_ff  <= OFF_W'(len_ff - LEN_W'(1));
         end else if (align_ff) begin
            if (fixed_ff && a0_wild) begin
               if (last_ff == '0) begin
                  fixed_ff <= 1'b0;
                  align_ff <= 1'b0;
               end else begin
                  last_ff <= last_ff - OFF_W'(1);
               end
            end else begin
               align_ff <= 1'b0;
            end
         end else if (op_clear) begin
            len_ff   <= '0;
            fixed_ff <= 1'b0;
            last_ff  <= '0;
         end else if (op_pat) begin
            len_ff <= len_ff + LEN_W'(1);
            if (pat_fixed) begin
               fixed_ff <= 1'b1;
               last_ff  <= OFF_W'(len_ff);
            end
         end

         // text bookkeeping
         if (op_clear) begin
            fill_ff <= '0;
            pos_ff  <= '0;
         end else if (op_text) begin
            pos_ff <= pos_ff + POS_W'(1);
            if (fill_ff < LEN_MAX) begin
               fill_ff <= fill_ff + LEN_W'(1);
            end
         end

         if (op_text) begin
            pend_ff <= 1'b1;
         end else if (advance) begin
            pend_ff <= 1'b0;
         end

         if (advance) begin
            rsp_valid_ff <= match;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && match) begin
         rsp_start_ff <= fixed_ff ? (pos_ff - POS_W'(last_ff)) : pos_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_start = rsp_start_ff;

endmodule

`default_nettype wire
